@@ hw/rtl/asfm_pkg.sv @@
// Shared types and constants of the adaptive symbol frequency model.
`timescale 1ns / 1ps
package asfm_pkg;

    localparam int COUNT_W  = 15;
    localparam int LIMIT_W  = 14;
    localparam int ANSWER_W = 32;

    localparam logic [LIMIT_W-1:0]  RESCALE_RESET   = 14'h1fff;
    localparam logic [ANSWER_W-1:0] EIGHT_BIT_TOTAL = 32'd256;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_FREQ = 3'd1;
    localparam logic [2:0] OP_CUM  = 3'd2;
    localparam logic [2:0] OP_TOT  = 3'd3;
    localparam logic [2:0] OP_SYM  = 3'd4;

    // Decode of one request against the fixed formulas
    typedef struct packed {
        logic                dynamic;
        logic [ANSWER_W-1:0] answer;
        logic                ignored;
    } fixed_t;

endpackage

@@ hw/rtl/asfm_fixed.sv @@
// Context classification and fixed-formula answers for the 8-bit and static contexts.
`timescale 1ns / 1ps
module asfm_fixed #(
    parameter int NUM_CONTEXTS = 16
) (
    input  logic [2:0]      opcode,
    input  logic [15:0]     context_id,
    input  logic [15:0]     symbol_value,
    input  logic [15:0]     frequency_value,
    output asfm_pkg::fixed_t fixed
);
    import asfm_pkg::*;

    // Dynamic contexts are 1 .. NUM_CONTEXTS-1
    always_comb
    begin
        fixed.dynamic = (context_id != 16'd0) &&
                        (32'(context_id) < 32'(NUM_CONTEXTS));
        fixed.answer  = '0;
        fixed.ignored = 1'b0;
        unique case (opcode)
            OP_ADD:  fixed.ignored = 1'b1;
            OP_FREQ: fixed.answer  = 32'd1;
            OP_CUM:  fixed.answer  = 32'(symbol_value) - 32'd1;
            OP_TOT:
            begin
                if (context_id == 16'd0)
                    fixed.answer = EIGHT_BIT_TOTAL;
                else
                    fixed.answer = 32'(context_id) - 32'(NUM_CONTEXTS);
            end
            OP_SYM:  fixed.answer  = 32'(frequency_value) + 32'd1;
            default: fixed.answer  = '0;
        endcase
    end

endmodule

@@ hw/rtl/adaptive_symbol_frequency_model_top.sv @@
// Top level: count memories, entry-walking sequencer and handshakes.
// Fixed contexts answer without a memory walk; dynamic requests read the context total first;
// a symbol lookup walks symbols upward; an add walks 0..symbol, after a downward rescale pass.
// The count memories have a single read port, so each entry walked is read first and then
// updated or compared. One item in flight at a time.
// Reset: a clearing pass over all NUM_CONTEXTS*MAX_SYMBOLS entries writes the reset
// counts; requests are stalled during it, configuration writes are taken.
`timescale 1ns / 1ps
module adaptive_symbol_frequency_model_top #(
    parameter int NUM_CONTEXTS = 16,
    parameter int MAX_SYMBOLS  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  opcode,
    input  logic [15:0] context_id,
    input  logic [15:0] symbol_value,
    input  logic [15:0] frequency_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] answer,
    output logic        symbol_ignored
);
    import asfm_pkg::*;

    localparam int DEPTH  = NUM_CONTEXTS * MAX_SYMBOLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(NUM_CONTEXTS);
    localparam int SW     = $clog2(MAX_SYMBOLS);
    localparam logic [SW-1:0]     LAST_SYM  = SW'(MAX_SYMBOLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_TOT_RD  = 4'd2;
    localparam logic [3:0] S_TOT     = 4'd3;
    localparam logic [3:0] S_RS_RD   = 4'd4;
    localparam logic [3:0] S_RS_WR   = 4'd5;
    localparam logic [3:0] S_INC_RD  = 4'd6;
    localparam logic [3:0] S_INC_WR  = 4'd7;
    localparam logic [3:0] S_Q_RD    = 4'd8;
    localparam logic [3:0] S_Q       = 4'd9;
    localparam logic [3:0] S_FIND_RD = 4'd10;
    localparam logic [3:0] S_FIND    = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [SW-1:0]       clr_sym_reg, clr_sym_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [2:0]          op_reg, op_next;
    logic [CW-1:0]       ctx_reg, ctx_next;
    logic [SW-1:0]       sym_reg, sym_next;
    logic                sym_big_reg, sym_big_next;
    logic [15:0]         freq_reg, freq_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0]  acc_reg, acc_next;
    logic [ANSWER_W-1:0] ans_reg, ans_next;
    logic                ign_reg, ign_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [ANSWER_W-1:0] answer_reg, answer_next;
    logic                ignored_reg, ignored_next;

    logic [COUNT_W-1:0]  sc_mem  [DEPTH];
    logic [COUNT_W-1:0]  cum_mem [DEPTH];
    logic [COUNT_W-1:0]  sc_rd_reg, cum_rd_reg;
    logic [SW-1:0]       rd_sym;
    logic [ADDR_W-1:0]   raddr, waddr;
    logic                sc_we, cum_we;
    logic [COUNT_W-1:0]  sc_wdata, cum_wdata;

    logic [COUNT_W-1:0]  half, acc_sum;
    logic [ANSWER_W-1:0] cum_below;
    logic                accept, rsp_free;
    fixed_t              fixed;

    asfm_fixed #(
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_fixed (
        .opcode          (opcode),
        .context_id      (context_id),
        .symbol_value    (symbol_value),
        .frequency_value (frequency_value),
        .fixed           (fixed)
    );

    assign cfg_ready      = 1'b1;
    assign req_stall      = (state_reg != S_IDLE);
    assign accept         = req_valid && !req_stall;
    assign rsp_valid      = rsp_valid_reg;
    assign answer         = answer_reg;
    assign symbol_ignored = ignored_reg;
    assign rsp_free       = !rsp_valid_reg || !rsp_stall;

    // Entry address within the current context
    assign raddr = ADDR_W'(ADDR_W'(ctx_reg) * ADDR_W'(MAX_SYMBOLS)) + ADDR_W'(rd_sym);

    // Shared datapath: halving add and distance below the total
    assign half      = sc_rd_reg >> 1;
    assign acc_sum   = acc_reg + half;
    assign cum_below = 32'(total_reg) - 32'(cum_rd_reg);

    // Count memories: one read address, one write address
    always_ff @(posedge clk)
    begin
        if (sc_we)
            sc_mem[waddr] <= sc_wdata;
        if (cum_we)
            cum_mem[waddr] <= cum_wdata;
        sc_rd_reg  <= sc_mem[raddr];
        cum_rd_reg <= cum_mem[raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_sym_next   = clr_sym_reg;
        op_next        = op_reg;
        ctx_next       = ctx_reg;
        sym_next       = sym_reg;
        sym_big_next   = sym_big_reg;
        freq_next      = freq_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        acc_next       = acc_reg;
        ans_next       = ans_reg;
        ign_next       = ign_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        answer_next    = answer_reg;
        ignored_next   = ignored_reg;
        rd_sym         = '0;
        waddr          = raddr;
        sc_we          = 1'b0;
        cum_we         = 1'b0;
        sc_wdata       = '0;
        cum_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                waddr     = clr_addr_reg;
                sc_we     = 1'b1;
                cum_we    = 1'b1;
                sc_wdata  = (clr_sym_reg == '0) ? COUNT_W'(1) : '0;
                cum_wdata = sc_wdata;
                clr_addr_next = clr_addr_reg + 1'b1;
                clr_sym_next  = (clr_sym_reg == LAST_SYM) ? '0 : clr_sym_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = opcode;
                    ctx_next     = context_id[CW-1:0];
                    sym_next     = symbol_value[SW-1:0];
                    sym_big_next = 32'(symbol_value) >= 32'(MAX_SYMBOLS);
                    freq_next    = frequency_value;
                    ans_next     = '0;
                    ign_next     = 1'b0;
                    if (!fixed.dynamic || opcode > OP_SYM)
                    begin
                        ans_next   = (opcode > OP_SYM) ? '0 : fixed.answer;
                        ign_next   = (opcode > OP_SYM) ? 1'b0 : fixed.ignored;
                        state_next = S_DONE;
                    end
                    else if (sym_big_next && (opcode == OP_ADD || opcode == OP_FREQ))
                    begin
                        ign_next   = (opcode == OP_ADD);
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_TOT_RD;
                end
            end
            S_TOT_RD:
            begin
                rd_sym     = '0;
                state_next = S_TOT;
            end
            S_TOT:
            begin
                total_next = cum_rd_reg;
                state_next = S_DONE;
                case (op_reg)
                    OP_ADD:
                    begin
                        acc_next = '0;
                        if (cum_rd_reg >= COUNT_W'(limit_reg))
                        begin
                            idx_next   = LAST_SYM;
                            state_next = S_RS_RD;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_INC_RD;
                        end
                    end
                    OP_FREQ: state_next = S_Q_RD;
                    OP_CUM:
                    begin
                        if (sym_big_reg)
                            ans_next = 32'(cum_rd_reg);
                        else
                            state_next = S_Q_RD;
                    end
                    OP_TOT: ans_next = 32'(cum_rd_reg);
                    default:
                    begin
                        if (freq_reg != 16'd0 && 16'(cum_rd_reg) >= freq_reg)
                        begin
                            idx_next   = '0;
                            state_next = S_FIND_RD;
                        end
                    end
                endcase
            end
            S_RS_RD:
            begin
                rd_sym     = idx_reg;
                state_next = S_RS_WR;
            end
            S_RS_WR:
            begin
                rd_sym   = idx_reg;
                sc_we    = 1'b1;
                cum_we   = 1'b1;
                acc_next = acc_sum;
                if (idx_reg == '0)
                begin
                    // Symbol 0 keeps one extra count
                    sc_wdata   = half + 1'b1;
                    cum_wdata  = acc_sum + 1'b1;
                    state_next = S_INC_RD;
                end
                else
                begin
                    sc_wdata   = half;
                    cum_wdata  = acc_sum;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_RS_RD;
                end
            end
            S_INC_RD:
            begin
                rd_sym     = idx_reg;
                state_next = S_INC_WR;
            end
            S_INC_WR:
            begin
                rd_sym    = idx_reg;
                cum_we    = 1'b1;
                cum_wdata = cum_rd_reg + 1'b1;
                sc_wdata  = sc_rd_reg + 1'b1;
                if (idx_reg == sym_reg)
                begin
                    sc_we      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_INC_RD;
                end
            end
            S_Q_RD:
            begin
                rd_sym     = sym_reg;
                state_next = S_Q;
            end
            S_Q:
            begin
                ans_next   = (op_reg == OP_FREQ) ? 32'(sc_rd_reg) : cum_below;
                state_next = S_DONE;
            end
            S_FIND_RD:
            begin
                rd_sym     = idx_reg;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                state_next = S_DONE;
                if (cum_below <= 32'(freq_reg))
                begin
                    ans_next = 32'(idx_reg);
                    if (idx_reg != LAST_SYM)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    answer_next    = ans_reg;
                    ignored_next   = ign_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_sym_reg   <= '0;
            limit_reg     <= RESCALE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_sym_reg   <= clr_sym_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ctx_reg     <= ctx_next;
        sym_reg     <= sym_next;
        sym_big_reg <= sym_big_next;
        freq_reg    <= freq_next;
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        acc_reg     <= acc_next;
        ans_reg     <= ans_next;
        ign_reg     <= ign_next;
        answer_reg  <= answer_next;
        ignored_reg <= ignored_next;
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the adaptive symbol frequency model: predictor, stimulus and checks.
`timescale 1ns / 1ps
module tb;
    import asfm_pkg::*;

    localparam int N_CTX = 16;
    localparam int N_SYM = 256;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  opcode = '0;
    logic [15:0] context_id = '0;
    logic [15:0] symbol_value = '0;
    logic [15:0] frequency_value = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] answer;
    logic        symbol_ignored;

    adaptive_symbol_frequency_model_top #(
        .NUM_CONTEXTS(N_CTX),
        .MAX_SYMBOLS (N_SYM)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .opcode         (opcode),
        .context_id     (context_id),
        .symbol_value   (symbol_value),
        .frequency_value(frequency_value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .answer         (answer),
        .symbol_ignored (symbol_ignored)
    );

    always #1 clk = ~clk;

    // Model state
    logic [14:0] sym_cnt [N_CTX*N_SYM];
    logic [14:0] cum_cnt [N_CTX*N_SYM];
    logic [13:0] limit_reg;

    typedef struct {
        logic [31:0] answer;
        logic        ignored;
    } beat_t;
    beat_t expected_beats[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic logic [31:0] cum_below(int base, logic [15:0] sym);
        logic [31:0] tot;
        begin
            tot = cum_cnt[base];
            if (sym >= N_SYM) return tot;
            return tot - cum_cnt[base + sym];
        end
    endfunction

    // Compute the beat a request produces and update the counts
    function automatic beat_t predict_counts(logic [2:0] op, logic [15:0] ctx,
                                             logic [15:0] sym, logic [15:0] freq);
        beat_t r;
        bit dyn;
        int base;
        logic [31:0] acc;
        begin
            r.answer = '0;
            r.ignored = 1'b0;
            dyn = (ctx != 0) && (ctx < N_CTX);
            base = dyn ? ctx * N_SYM : 0;
            case (op)
                OP_ADD:
                    if (dyn && sym < N_SYM) begin
                        if ({17'd0, cum_cnt[base]} >= {18'd0, limit_reg}) begin
                            acc = 0;
                            for (int i = N_SYM - 1; i >= 0; i--) begin
                                sym_cnt[base+i] = sym_cnt[base+i] >> 1;
                                acc += sym_cnt[base+i];
                                cum_cnt[base+i] = acc[14:0];
                            end
                            sym_cnt[base] = sym_cnt[base] + 15'd1;
                            cum_cnt[base] = cum_cnt[base] + 15'd1;
                        end
                        sym_cnt[base+sym] = sym_cnt[base+sym] + 15'd1;
                        for (int i = 0; i <= sym; i++)
                            cum_cnt[base+i] = cum_cnt[base+i] + 15'd1;
                    end else begin
                        r.ignored = 1'b1;
                    end
                OP_FREQ:
                    if (dyn) r.answer = (sym < N_SYM) ? {17'd0, sym_cnt[base+sym]} : 32'd0;
                    else r.answer = 32'd1;
                OP_CUM:
                    if (dyn) r.answer = cum_below(base, sym);
                    else r.answer = {16'd0, sym} - 32'd1;
                OP_TOT:
                    if (dyn) r.answer = {17'd0, cum_cnt[base]};
                    else if (ctx == 0) r.answer = EIGHT_BIT_TOTAL;
                    else r.answer = {16'd0, ctx} - N_CTX;
                OP_SYM:
                    if (dyn) begin
                        if (freq != 0 && {17'd0, cum_cnt[base]} >= {16'd0, freq}) begin
                            for (int i = 0; i < N_SYM; i++) begin
                                if (cum_below(base, i[15:0]) <= {16'd0, freq}) r.answer = i;
                                else break;
                            end
                        end
                    end else begin
                        r.answer = {16'd0, freq} + 32'd1;
                    end
                default: ;
            endcase
            return r;
        end
    endfunction

    // Send one request beat, predicting at acceptance
    task automatic send_req(logic [2:0] op, logic [15:0] ctx, logic [15:0] sym,
                            logic [15:0] freq);
        begin
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
            req_valid <= 1'b1;
            opcode <= op;
            context_id <= ctx;
            symbol_value <= sym;
            frequency_value <= freq;
            @(posedge clk);
            while (req_stall) @(posedge clk);
            expected_beats.push_back(predict_counts(op, ctx, sym, freq));
            req_valid <= 1'b0;
            // Block is busy for at least this cycle after taking a beat
            @(posedge clk);
        end
    endtask

    // Write the rescale limit once the block is drained
    task automatic write_limit(logic [13:0] v);
        begin
            while (expected_beats.size() != 0) @(posedge clk);
            repeat (2 * N_SYM + 2 * N_SYM + 20) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= v;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            limit_reg = v;
            cfg_valid <= 1'b0;
        end
    endtask

    // Response stall generator
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    // Result checker
    always @(posedge clk) begin
        beat_t e;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: answer %0h ignored %0b", answer, symbol_ignored);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (answer !== e.answer) begin
                    $error("answer: expected %0h actual %0h", e.answer, answer);
                    errors++;
                end
                if (symbol_ignored !== e.ignored) begin
                    $error("symbol_ignored: expected %0b actual %0b", e.ignored,
                           symbol_ignored);
                    errors++;
                end
            end
        end
    end

    function automatic logic [15:0] pick_ctx();
        int k;
        begin
            k = $urandom_range(19);
            if (k < 15) return 16'($urandom_range(N_CTX - 1, 1));
            if (k == 15) return 16'd0;
            if (k == 16) return 16'hffff;
            return 16'($urandom_range(65535, N_CTX));
        end
    endfunction

    function automatic logic [15:0] pick_sym();
        int k;
        begin
            k = $urandom_range(9);
            if (k < 5) return 16'($urandom_range(7));
            if (k < 9) return 16'($urandom_range(N_SYM - 1));
            return 16'($urandom);
        end
    endfunction

    task automatic random_items(int n);
        logic [2:0] op;
        logic [15:0] ctx;
        begin
            for (int i = 0; i < n; i++) begin
                op = ($urandom_range(1) != 0) ? OP_ADD : 3'($urandom_range(7));
                ctx = pick_ctx();
                send_req(op, ctx, pick_sym(),
                         ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(40)));
            end
        end
    endtask

    // Directed: extremes, every defined opcode, static/fixed contexts, dropped adds
    task automatic test_directed();
        begin
            send_req(OP_TOT, 16'd3, 16'd0, 16'd0);
            send_req(OP_SYM, 16'd3, 16'd0, 16'd1);
            send_req(OP_CUM, 16'd3, 16'd1, 16'd0);
            send_req(OP_ADD, 16'd3, 16'd255, 16'd0);
            send_req(OP_ADD, 16'd3, 16'd0, 16'd0);
            send_req(OP_ADD, 16'd3, 16'd256, 16'd0);
            send_req(OP_ADD, 16'd0, 16'd1, 16'd0);
            send_req(OP_ADD, 16'd20, 16'd1, 16'd0);
            send_req(OP_FREQ, 16'd3, 16'd255, 16'd0);
            send_req(OP_FREQ, 16'd3, 16'hffff, 16'd0);
            send_req(OP_CUM, 16'd3, 16'hffff, 16'd0);
            send_req(OP_SYM, 16'd3, 16'd0, 16'd0);
            send_req(OP_SYM, 16'd3, 16'd0, 16'd2);
            send_req(OP_SYM, 16'd3, 16'd0, 16'hffff);
            send_req(OP_FREQ, 16'd0, 16'd5, 16'd0);
            send_req(OP_CUM, 16'd0, 16'd0, 16'd0);
            send_req(OP_CUM, 16'hffff, 16'hffff, 16'd0);
            send_req(OP_TOT, 16'd0, 16'd0, 16'd0);
            send_req(OP_TOT, 16'hffff, 16'd0, 16'd0);
            send_req(OP_TOT, 16'd16, 16'd0, 16'd0);
            send_req(OP_SYM, 16'd0, 16'd0, 16'hffff);
            send_req(3'd5, 16'd3, 16'd1, 16'd1);
            send_req(3'd7, 16'd0, 16'd0, 16'd0);
        end
    endtask

    // Low limits force frequent rescales; a high limit is also tried
    task automatic test_rescale();
        begin
            write_limit(14'd2);
            random_items(150);
            write_limit(14'd0);
            random_items(40);
            write_limit(14'd1);
            random_items(40);
            write_limit(14'h3fff);
            random_items(60);
            write_limit(14'd9);
        end
    endtask

    task automatic test_traffic();
        begin
            send_idle_pct = 0;  recv_stall_pct = 0;  random_items(180);
            send_idle_pct = 61; recv_stall_pct = 0;  random_items(180);
            send_idle_pct = 0;  recv_stall_pct = 61; random_items(180);
            send_idle_pct = 38; recv_stall_pct = 38; random_items(180);
            send_idle_pct = 0;  recv_stall_pct = 0;
        end
    endtask

    initial begin
        for (int c = 0; c < N_CTX*N_SYM; c++) begin
            sym_cnt[c] = '0;
            cum_cnt[c] = '0;
        end
        for (int c = 0; c < N_CTX; c++) begin
            sym_cnt[c*N_SYM] = 15'd1;
            cum_cnt[c*N_SYM] = 15'd1;
        end
        limit_reg = RESCALE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_traffic();
        test_rescale();
        write_limit(14'd300);
        random_items(40);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit
    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/asfm_pkg.sv
hw/rtl/asfm_fixed.sv
hw/rtl/adaptive_symbol_frequency_model_top.sv
tb/sv/tb.sv
